>>> hdl/mlf_pkg.sv
package mlf_pkg;

	localparam int JobBytes   = 5;
	localparam int QueueDepth = 4;
	localparam int PtrWidth   = $clog2(QueueDepth);

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_TOGGLE = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam logic CFG_LINE_BYTES = 1'b0;
	localparam logic CFG_LINE_COUNT = 1'b1;

	localparam logic [7:0] BIT_WRITE = 8'h01;
	localparam logic [7:0] BIT_VCOM  = 8'h02;
	localparam logic [7:0] BIT_CLEAR = 8'h04;
	localparam logic [7:0] TRAILER   = 8'h00;

	localparam logic [6:0] LINE_BYTES_RESET = 7'd50;
	localparam logic [8:0] LINE_COUNT_RESET = 9'd240;
	localparam logic [6:0] LINE_BYTES_MAX   = 7'd64;
	localparam logic [8:0] LINE_COUNT_MAX   = 9'd256;

	// Bytes of one item in transmit order, starting at index zero.
	typedef struct packed {
		logic [JobBytes-1:0][7:0] bytes;
		logic [2:0]               count;
		logic                     last;
	} job_t;

endpackage

>>> hdl/mlf_front.sv
module mlf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        pixel_byte,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [8:0]        cfg_data,
	input  logic              q_full,
	output logic              push,
	output mlf_pkg::job_t     push_job
);

	logic [6:0]      line_bytes_q;
	logic [8:0]      line_count_q;
	logic            vcom_q;
	logic [7:0]      row_q;
	logic [5:0]      col_q;
	logic [6:0]      lb;
	logic [8:0]      lc;
	logic [6:0]      col_next;
	logic [8:0]      row_next;
	logic            col_end;
	logic            frame_end;
	logic            accept;
	logic [2:0]      idx;
	logic [7:0]      cmd_base;
	mlf_pkg::kind_t  kind_c;
	mlf_pkg::job_t   job;

	assign kind_c   = mlf_pkg::kind_t'(kind);
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		if (line_bytes_q == 7'd0) begin
			lb = 7'd1;
		end else if (line_bytes_q > mlf_pkg::LINE_BYTES_MAX) begin
			lb = mlf_pkg::LINE_BYTES_MAX;
		end else begin
			lb = line_bytes_q;
		end
		if (line_count_q == 9'd0) begin
			lc = 9'd1;
		end else if (line_count_q > mlf_pkg::LINE_COUNT_MAX) begin
			lc = mlf_pkg::LINE_COUNT_MAX;
		end else begin
			lc = line_count_q;
		end
	end

	assign col_next  = {1'b0, col_q} + 7'd1;
	assign row_next  = {1'b0, row_q} + 9'd1;
	assign col_end   = col_next >= lb;
	assign frame_end = row_next >= lc;
	assign cmd_base  = vcom_q ? mlf_pkg::BIT_VCOM : 8'h00;

	always_comb begin
		job = '0;
		idx = 3'd0;
		unique case (kind_c)
			mlf_pkg::KIND_CLEAR: begin
				job.bytes[0] = cmd_base | mlf_pkg::BIT_CLEAR;
				job.bytes[1] = mlf_pkg::TRAILER;
				job.count    = 3'd2;
				job.last     = 1'b1;
			end
			mlf_pkg::KIND_PIXEL: begin
				if (col_q == 6'd0) begin
					if (row_q == 8'd0) begin
						job.bytes[idx] = cmd_base | mlf_pkg::BIT_WRITE;
						idx = idx + 3'd1;
					end
					job.bytes[idx] = row_q;
					idx = idx + 3'd1;
				end
				job.bytes[idx] = pixel_byte;
				idx = idx + 3'd1;
				if (col_end) begin
					job.bytes[idx] = mlf_pkg::TRAILER;
					idx = idx + 3'd1;
					if (frame_end) begin
						job.bytes[idx] = mlf_pkg::TRAILER;
						idx = idx + 3'd1;
						job.last = 1'b1;
					end
				end
				job.count = idx;
			end
			mlf_pkg::KIND_TOGGLE, mlf_pkg::KIND_UNUSED: begin
				job = '0;
			end
		endcase
	end

	assign push     = accept && (job.count != 3'd0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= mlf_pkg::LINE_BYTES_RESET;
			line_count_q <= mlf_pkg::LINE_COUNT_RESET;
			vcom_q       <= 1'b1;
			row_q        <= 8'd0;
			col_q        <= 6'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mlf_pkg::CFG_LINE_BYTES: line_bytes_q <= cfg_data[6:0];
					mlf_pkg::CFG_LINE_COUNT: line_count_q <= cfg_data;
				endcase
			end
			if (accept) begin
				unique case (kind_c)
					mlf_pkg::KIND_CLEAR: begin
						vcom_q <= !vcom_q;
						row_q  <= 8'd0;
						col_q  <= 6'd0;
					end
					mlf_pkg::KIND_TOGGLE: begin
						vcom_q <= !vcom_q;
					end
					mlf_pkg::KIND_PIXEL: begin
						if (col_end) begin
							col_q <= 6'd0;
							row_q <= frame_end ? 8'd0 : row_next[7:0];
						end else begin
							col_q <= col_next[5:0];
						end
					end
					mlf_pkg::KIND_UNUSED: begin
						vcom_q <= vcom_q;
					end
				endcase
			end
		end
	end

endmodule

>>> hdl/mlf_queue.sv
module mlf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mlf_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output mlf_pkg::job_t  pop_job
);

	localparam logic [mlf_pkg::PtrWidth:0] Depth = (mlf_pkg::PtrWidth + 1)'(mlf_pkg::QueueDepth);

	mlf_pkg::job_t                  entry_q [mlf_pkg::QueueDepth];
	logic [mlf_pkg::PtrWidth-1:0]   wr_ptr_q;
	logic [mlf_pkg::PtrWidth-1:0]   rd_ptr_q;
	logic [mlf_pkg::PtrWidth:0]     fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = fill_q == Depth;
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/mlf_back.sv
module mlf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  mlf_pkg::job_t  q_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           last
);

	mlf_pkg::job_t  cur_q;
	logic           cur_valid_q;
	logic [2:0]     pos_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;
	logic           load_ok;
	logic           emit;
	logic           cur_done;

	assign load_ok  = !out_valid_q || !out_stall;
	assign emit     = load_ok && cur_valid_q;
	assign cur_done = emit && (pos_q == (cur_q.count - 3'd1));
	assign pop      = (!cur_valid_q || cur_done) && !q_empty;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_q.bytes[pos_q];
			out_last_q <= cur_done && cur_q.last;
		end
		if (pop) begin
			cur_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_valid_q <= 1'b0;
			pos_q       <= 3'd0;
		end else begin
			if (load_ok) begin
				out_valid_q <= cur_valid_q;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= 3'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

endmodule

>>> hdl/memory_lcd_line_framer.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  kind, pixel_byte
// output   out        out_valid / out_stall out_byte, last
// config   in         cfg_we               cfg_index, cfg_data
//
// The front takes one item per cycle while the queue is not full and turns it into up to five bytes in one queue entry.
// The back sends one byte per cycle while out_stall is low, and an item carries
// one byte for a plain pixel, up to five at a frame start or end.
// Reset is asynchronous and active low; it restores the register defaults and VCOM set.
// A stalled output fills the four-entry queue, after which the input is stalled.
module memory_lcd_line_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  pixel_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic           push;
	logic           q_full;
	logic           q_empty;
	logic           pop;
	mlf_pkg::job_t  push_job;
	mlf_pkg::job_t  q_job;

	mlf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.pixel_byte (pixel_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	mlf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.pop_job  (q_job)
	);

	mlf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
